// ===== rtl/graph_label_propagation_clusterer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the label propagation clusterer
// The asserting module must provide clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef GRAPH_LABEL_PROPAGATION_CLUSTERER_TOP_DEFINES_SVH
`define GRAPH_LABEL_PROPAGATION_CLUSTERER_TOP_DEFINES_SVH

// plain property, sampled on clk_i, off during reset
`define GLPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication
`define GLPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/glpc_pkg.sv =====
// ----------------------------------------------------------------------------
// glpc_pkg
// Shared constants, function codes and helpers of the clusterer.
// ----------------------------------------------------------------------------
package glpc_pkg;

  localparam int unsigned NodeCountDef   = 256;
  localparam int unsigned MaxDegreeDef   = 16;
  localparam int unsigned LatencyBitsDef = 16;
  localparam logic [15:0] FloorReset     = 16'd10000;

  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_RELABEL = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_INIT    = 2'd3
  } func_e;

  // id modulo m by restoring subtraction, eight narrow steps
  function automatic logic [7:0] wrap_id(input logic [7:0] v, input int unsigned m);
    logic [31:0] r;
    r = {24'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (32'(m) << k)) begin
        r = r - (32'(m) << k);
      end
    end
    return r[7:0];
  endfunction

endpackage

// ===== rtl/glpc_ram.sv =====
// ----------------------------------------------------------------------------
// glpc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module glpc_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/glpc_vram.sv =====
// ----------------------------------------------------------------------------
// glpc_vram
// RAM with a valid flop per entry; unwritten entries read as a fill value
// (zero or the entry's own address). clr_i drops all valid bits at once.
// ----------------------------------------------------------------------------
module glpc_vram #(
  parameter int unsigned W          = 8,
  parameter int unsigned DEPTH      = 256,
  parameter bit          FILL_INDEX = 1'b0,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0]     mem [DEPTH];
  logic [W-1:0]     rdata_q;
  logic [AW-1:0]    raddr_q;
  logic             rvld_q;
  logic [DEPTH-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
    raddr_q <= raddr_i;
    rvld_q  <= vld_q[raddr_i];
  end

  assign rdata_o = rvld_q ? rdata_q : (FILL_INDEX ? W'(raddr_q) : '0);

endmodule

// ===== rtl/graph_label_propagation_clusterer_top.sv =====
// ----------------------------------------------------------------------------
// graph_label_propagation_clusterer_top
// Label propagation clusterer over weighted adjacency lists.
// ----------------------------------------------------------------------------
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Add edge reads both degrees, then writes the node's and the peer's slots;
// a dropped edge skips the writes. Add edge and init end with a label read.
// A relabel of a node without edges returns its current label. Otherwise the
// registered-read memories set its cost: each neighbor takes an adjacency
// read, a label read and a score write in the first pass, then a score read
// and one compare in the second pass, all on one shared compare unit. A
// finished result sits in the output register while the next input beat is
// already taken; the sequencer only waits in its last state when the output
// register is still full. No clearing pass after reset. The user must write
// score_floor through cfg_we_i / cfg_wdata_i only while idle; not enforced.
// ----------------------------------------------------------------------------
`include "graph_label_propagation_clusterer_top_defines.svh"

module graph_label_propagation_clusterer_top #(
  parameter int unsigned NODE_COUNT   = glpc_pkg::NodeCountDef,
  parameter int unsigned MAX_DEGREE   = glpc_pkg::MaxDegreeDef,
  parameter int unsigned LATENCY_BITS = glpc_pkg::LatencyBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  node_id_i,
  input  logic [7:0]  peer_id_i,
  input  logic [15:0] latency_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  label_o,
  output logic        changed_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  // only ids 0..255 ever reach the stores
  localparam int unsigned NodeDepth = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int unsigned IdW       = $clog2(NodeDepth);
  localparam int unsigned AdjDepth  = NodeDepth * MAX_DEGREE;
  localparam int unsigned AdrW      = $clog2(AdjDepth);
  localparam int unsigned DegW      = $clog2(MAX_DEGREE + 1);
  localparam int unsigned SlotW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned CmpW      = (LATENCY_BITS > 16) ? LATENCY_BITS : 16;
  localparam int unsigned AdjW      = IdW + LATENCY_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_A, S_ADD_B, S_ADD_C, S_ADD_D,
    S_RL_0, S_RL_1, S_P1_A, S_P1_B, S_P1_C, S_P2_A, S_P2_B, S_RL_W,
    S_INIT, S_RD_A, S_RD_B, S_DONE
  } state_e;

  state_e                  state_q;
  logic [IdW-1:0]          node_q, peer_q;
  logic [LATENCY_BITS-1:0] lat_q;
  logic [DegW-1:0]         deg_a_q, deg_b_q, idx_q;
  logic [7:0]              old_q, best_q, res_label_q;
  logic [LATENCY_BITS-1:0] best_lat_q;
  logic                    found_q, res_changed_q, res_status_q;
  logic [7:0]              labq_q [MAX_DEGREE];
  logic                    out_valid_q;
  logic [7:0]              label_q;
  logic                    changed_q, status_q;
  logic [15:0]             floor_q;

  // memory ports
  logic                 a_we;
  logic [AdrW-1:0]      a_waddr, a_raddr;
  logic [AdjW-1:0]      a_wdata, a_rdata;
  logic                 d_we;
  logic [IdW-1:0]       d_waddr, d_raddr;
  logic [DegW-1:0]      d_wdata, d_rdata;
  logic                 l_clr, l_we;
  logic [IdW-1:0]       l_waddr, l_raddr;
  logic [7:0]           l_wdata, l_rdata;
  logic                 s_we;
  logic [IdW-1:0]       s_waddr, s_raddr;
  logic [LATENCY_BITS-1:0] s_wdata, s_rdata;

  logic [CmpW-1:0]         lat_ext;
  logic [LATENCY_BITS-1:0] lat_in;
  logic                    accept;
  logic                    last_idx;
  logic [7:0]              new_label;
  logic                    qualify, better;
  logic [7:0]              cand_lab;
  logic [DegW:0]           self_need;
  logic                    add_full;

  function automatic logic [AdrW-1:0] slot_addr(input logic [IdW-1:0] n,
                                                input logic [DegW-1:0] i);
    return AdrW'(n) * AdrW'(MAX_DEGREE) + AdrW'(i);
  endfunction

  assign lat_ext  = CmpW'(latency_i);
  assign lat_in   = lat_ext[LATENCY_BITS-1:0];
  assign accept   = in_valid_i && in_ready_o;
  assign last_idx = (idx_q + DegW'(1)) == deg_a_q;

  // shared compare unit: floor check and best-so-far, ties to smaller label
  assign cand_lab = labq_q[idx_q[SlotW-1:0]];
  assign qualify  = CmpW'(s_rdata) < CmpW'(floor_q);
  assign better   = !found_q || (s_rdata < best_lat_q) ||
                    ((s_rdata == best_lat_q) && (cand_lab < best_q));
  assign new_label = found_q ? best_q : 8'd0;

  // add-edge room check; a self-loop takes two slots
  assign self_need = {1'b0, deg_a_q} + (DegW + 1)'(2);
  assign add_full  = (node_q == peer_q)
                   ? (self_need > (DegW + 1)'(MAX_DEGREE))
                   : ((deg_a_q >= DegW'(MAX_DEGREE)) || (d_rdata >= DegW'(MAX_DEGREE)));

  // memory control decode
  always_comb begin
    a_we    = 1'b0;
    a_waddr = slot_addr(node_q, deg_a_q);
    a_wdata = {peer_q, lat_q};
    a_raddr = slot_addr(node_q, idx_q);
    d_we    = 1'b0;
    d_waddr = node_q;
    d_wdata = deg_a_q + DegW'(1);
    d_raddr = node_q;
    l_clr   = 1'b0;
    l_we    = 1'b0;
    l_waddr = node_q;
    l_wdata = new_label;
    l_raddr = node_q;
    s_we    = 1'b0;
    s_waddr = l_rdata[IdW-1:0];
    s_wdata = lat_q;
    s_raddr = cand_lab[IdW-1:0];
    unique case (state_q)
      S_ADD_B: d_raddr = peer_q;
      S_ADD_C: begin
        if (!add_full) begin
          a_we = 1'b1;
          d_we = 1'b1;
        end
      end
      S_ADD_D: begin
        a_we    = 1'b1;
        a_waddr = slot_addr(peer_q, deg_b_q);
        a_wdata = {node_q, lat_q};
        d_we    = 1'b1;
        d_waddr = peer_q;
        d_wdata = deg_b_q + DegW'(1);
      end
      S_P1_B:  l_raddr = a_rdata[AdjW-1:LATENCY_BITS];
      S_P1_C:  s_we = 1'b1;
      S_RL_W:  l_we = 1'b1;
      S_INIT:  l_clr = 1'b1;
      default: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // output register loads from the last state, else empties on a beat
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            node_q        <= IdW'(glpc_pkg::wrap_id(node_id_i, NODE_COUNT));
            peer_q        <= IdW'(glpc_pkg::wrap_id(peer_id_i, NODE_COUNT));
            lat_q         <= lat_in;
            res_changed_q <= 1'b0;
            res_status_q  <= 1'b0;
            unique case (glpc_pkg::func_e'(func_i))
              glpc_pkg::FUNC_ADD:     state_q <= S_ADD_A;
              glpc_pkg::FUNC_RELABEL: state_q <= S_RL_0;
              glpc_pkg::FUNC_READ:    state_q <= S_RD_A;
              glpc_pkg::FUNC_INIT:    state_q <= S_INIT;
              default:                state_q <= S_IDLE;
            endcase
          end
        end
        S_ADD_A: state_q <= S_ADD_B;
        S_ADD_B: begin
          deg_a_q <= d_rdata;
          state_q <= S_ADD_C;
        end
        S_ADD_C: begin
          deg_b_q <= (node_q == peer_q) ? deg_a_q + DegW'(1) : d_rdata;
          if (add_full) begin
            res_status_q <= 1'b1;
            state_q      <= S_RD_A;
          end else begin
            state_q <= S_ADD_D;
          end
        end
        S_ADD_D: state_q <= S_RD_A;
        S_RL_0:  state_q <= S_RL_1;
        S_RL_1: begin
          deg_a_q <= d_rdata;
          old_q   <= l_rdata;
          idx_q   <= '0;
          found_q <= 1'b0;
          if (d_rdata == '0) begin
            res_label_q <= l_rdata;
            state_q     <= S_DONE;
          end else begin
            state_q <= S_P1_A;
          end
        end
        S_P1_A: state_q <= S_P1_B;
        S_P1_B: begin
          lat_q   <= a_rdata[LATENCY_BITS-1:0];
          state_q <= S_P1_C;
        end
        S_P1_C: begin
          labq_q[idx_q[SlotW-1:0]] <= l_rdata;
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= S_P2_A;
          end else begin
            idx_q   <= idx_q + DegW'(1);
            state_q <= S_P1_A;
          end
        end
        S_P2_A: state_q <= S_P2_B;
        S_P2_B: begin
          if (qualify && better) begin
            found_q    <= 1'b1;
            best_q     <= cand_lab;
            best_lat_q <= s_rdata;
          end
          if (last_idx) begin
            state_q <= S_RL_W;
          end else begin
            idx_q   <= idx_q + DegW'(1);
            state_q <= S_P2_A;
          end
        end
        S_RL_W: begin
          res_label_q   <= new_label;
          res_changed_q <= new_label != old_q;
          state_q       <= S_DONE;
        end
        S_INIT: state_q <= S_RD_A;
        S_RD_A: state_q <= S_RD_B;
        S_RD_B: begin
          res_label_q <= l_rdata;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            label_q   <= res_label_q;
            changed_q <= res_changed_q;
            status_q  <= res_status_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // score floor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= glpc_pkg::FloorReset;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign label_o     = label_q;
  assign changed_o   = changed_q;
  assign status_o    = status_q;

  // neighbor id and latency per slot
  glpc_ram #(.W(AdjW), .DEPTH(AdjDepth)) u_adj (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  // degree per node, zero until written
  glpc_vram #(.W(DegW), .DEPTH(NodeDepth), .FILL_INDEX(1'b0)) u_deg (
    .clk_i, .rst_ni, .clr_i(1'b0), .we_i(d_we), .waddr_i(d_waddr),
    .wdata_i(d_wdata), .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  // label per node, own id until written; init drops all valid bits
  glpc_vram #(.W(8), .DEPTH(NodeDepth), .FILL_INDEX(1'b1)) u_label (
    .clk_i, .rst_ni, .clr_i(l_clr), .we_i(l_we), .waddr_i(l_waddr),
    .wdata_i(l_wdata), .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  // latency of last edge per label, written in pass one before any read
  glpc_ram #(.W(LATENCY_BITS), .DEPTH(NodeDepth)) u_score (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  `GLPC_ASSERT_NEXT(a_busy_after_beat, accept, !in_ready_o, "ready after input beat")
  `GLPC_ASSERT_IMPL(a_idx_in_degree, (state_q == S_P1_C) || (state_q == S_P2_B), idx_q < deg_a_q, "neighbor index past degree")
  `GLPC_ASSERT_IMPL(a_deg_bound, d_we, d_wdata <= DegW'(MAX_DEGREE), "degree over limit")
  `GLPC_ASSERT(a_flags_exclusive, !(out_valid_q && changed_q && status_q), "changed and status both set")

endmodule
